// ----- hdl/led_status_pattern_sequencer_top_defines.svh -----
// Assertion macros for the LED status pattern sequencer.
`ifndef LED_STATUS_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define LED_STATUS_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LSPS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define LSPS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define LSPS_ASSERT_IMP(label, clk, rst_n, a, c)
`define LSPS_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- hdl/lsps_pkg.sv -----
package lsps_pkg;

  // Mode codes.
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SELF    = 4'd1;
  localparam logic [3:0] M_CFGING  = 4'd2;
  localparam logic [3:0] M_CFGOK   = 4'd3;
  localparam logic [3:0] M_NETERR  = 4'd4;
  localparam logic [3:0] M_DIALOG  = 4'd5;
  localparam logic [3:0] M_VOLUME  = 4'd6;
  localparam logic [3:0] M_BREATHE = 4'd7;
  localparam logic [3:0] M_WAKE    = 4'd8;
  localparam logic [3:0] M_STANDBY = 4'd9;

  // Timer commands.
  localparam logic [1:0] TC_LEAVE = 2'd0;
  localparam logic [1:0] TC_STOP  = 2'd1;
  localparam logic [1:0] TC_START = 2'd2;

  // Timer durations.
  localparam logic [3:0] TS_SELF_R   = 4'd0;
  localparam logic [3:0] TS_SELF_G   = 4'd1;
  localparam logic [3:0] TS_SELF_B   = 4'd2;
  localparam logic [3:0] TS_CFG_ON   = 4'd3;
  localparam logic [3:0] TS_CFG_OFF  = 4'd4;
  localparam logic [3:0] TS_BAR_STEP = 4'd5;
  localparam logic [3:0] TS_BAR_HOLD = 4'd6;
  localparam logic [3:0] TS_DLG_ON   = 4'd7;
  localparam logic [3:0] TS_DLG_OFF  = 4'd8;
  localparam logic [3:0] TS_VOLUME   = 4'd9;
  localparam logic [3:0] TS_BREATH   = 4'd10;
  localparam logic [3:0] TS_WAKE     = 4'd11;
  localparam logic [3:0] TS_WAKE_HLD = 4'd12;
  localparam logic [3:0] TS_CHASE    = 4'd13;

  localparam int unsigned LedCount = 12;

  // Frame kinds: solid fill, lit bar, or a single chase LED.
  typedef enum logic [1:0] {FK_SOLID, FK_BAR, FK_CHASE} frame_kind_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [3:0]  count;
  } frame_t;

  // Work for one input item, handed to the frame emitter.
  typedef struct packed {
    logic       n_frames_1;
    logic       n_frames_2;
    frame_t     f0;
    frame_t     f1;
    logic [1:0] tcmd;
    logic [3:0] tsel;
  } job_t;

  // Position of a physical LED in the lighting order 8,7,...,0,11,10,9.
  function automatic logic [3:0] ring_pos(input logic [3:0] led);
    logic [3:0] r;
    if (led <= 4'd8) r = 4'd8 - led;
    else r = 4'(5'd20 - {1'b0, led});
    return r;
  endfunction

  // Rising half of the table (entries 0 to 100); used for the falling half.
  function automatic logic [7:0] breath_lut_half(input logic [7:0] i);
    logic [7:0] v;
    case (i)
      8'd0,8'd1,8'd2,8'd3,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,8'd10: v = 8'd0;
      8'd11,8'd12,8'd13,8'd14,8'd15,8'd16,8'd17: v = 8'd1;
      8'd18,8'd19,8'd20,8'd21,8'd22: v = 8'd2;
      8'd23,8'd24,8'd25: v = 8'd3;
      8'd26,8'd27: v = 8'd4; 8'd28,8'd29: v = 8'd5; 8'd30,8'd31: v = 8'd6;
      8'd32,8'd33: v = 8'd7; 8'd34,8'd35: v = 8'd8;
      8'd36: v = 8'd9; 8'd37: v = 8'd10; 8'd38: v = 8'd11; 8'd39: v = 8'd12;
      8'd40: v = 8'd13; 8'd41: v = 8'd14; 8'd42: v = 8'd15; 8'd43: v = 8'd16;
      8'd44: v = 8'd17; 8'd45: v = 8'd18; 8'd46: v = 8'd20; 8'd47: v = 8'd21;
      8'd48: v = 8'd23; 8'd49: v = 8'd24; 8'd50: v = 8'd26; 8'd51: v = 8'd27;
      8'd52: v = 8'd29; 8'd53: v = 8'd31; 8'd54: v = 8'd33; 8'd55: v = 8'd35;
      8'd56: v = 8'd37; 8'd57: v = 8'd39; 8'd58: v = 8'd42; 8'd59: v = 8'd44;
      8'd60: v = 8'd47; 8'd61: v = 8'd49; 8'd62: v = 8'd52; 8'd63: v = 8'd55;
      8'd64: v = 8'd58; 8'd65: v = 8'd61; 8'd66: v = 8'd64; 8'd67: v = 8'd67;
      8'd68: v = 8'd71; 8'd69: v = 8'd74; 8'd70: v = 8'd78; 8'd71: v = 8'd82;
      8'd72: v = 8'd86; 8'd73: v = 8'd90; 8'd74: v = 8'd94; 8'd75: v = 8'd98;
      8'd76: v = 8'd103; 8'd77: v = 8'd107; 8'd78: v = 8'd112; 8'd79: v = 8'd117;
      8'd80: v = 8'd122; 8'd81: v = 8'd127; 8'd82: v = 8'd132; 8'd83: v = 8'd138;
      8'd84: v = 8'd143; 8'd85: v = 8'd149; 8'd86: v = 8'd155; 8'd87: v = 8'd161;
      8'd88: v = 8'd167; 8'd89: v = 8'd174; 8'd90: v = 8'd180; 8'd91: v = 8'd187;
      8'd92: v = 8'd194; 8'd93: v = 8'd201; 8'd94: v = 8'd208; 8'd95: v = 8'd215;
      8'd96: v = 8'd223; 8'd97: v = 8'd230; 8'd98: v = 8'd238; 8'd99: v = 8'd246;
      default: v = 8'd254;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] breath_lut(input logic [7:0] i);
    logic [7:0] v;
    logic [7:0] j;
    case (i)
      8'd0,8'd1,8'd2,8'd3,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,8'd10: v = 8'd0;
      8'd11,8'd12,8'd13,8'd14,8'd15,8'd16,8'd17: v = 8'd1;
      8'd18,8'd19,8'd20,8'd21,8'd22: v = 8'd2;
      8'd23,8'd24,8'd25: v = 8'd3;
      8'd26,8'd27: v = 8'd4; 8'd28,8'd29: v = 8'd5; 8'd30,8'd31: v = 8'd6;
      8'd32,8'd33: v = 8'd7; 8'd34,8'd35: v = 8'd8;
      8'd36: v = 8'd9; 8'd37: v = 8'd10; 8'd38: v = 8'd11; 8'd39: v = 8'd12;
      8'd40: v = 8'd13; 8'd41: v = 8'd14; 8'd42: v = 8'd15; 8'd43: v = 8'd16;
      8'd44: v = 8'd17; 8'd45: v = 8'd18; 8'd46: v = 8'd20; 8'd47: v = 8'd21;
      8'd48: v = 8'd23; 8'd49: v = 8'd24; 8'd50: v = 8'd26; 8'd51: v = 8'd27;
      8'd52: v = 8'd29; 8'd53: v = 8'd31; 8'd54: v = 8'd33; 8'd55: v = 8'd35;
      8'd56: v = 8'd37; 8'd57: v = 8'd39; 8'd58: v = 8'd42; 8'd59: v = 8'd44;
      8'd60: v = 8'd47; 8'd61: v = 8'd49; 8'd62: v = 8'd52; 8'd63: v = 8'd55;
      8'd64: v = 8'd58; 8'd65: v = 8'd61; 8'd66: v = 8'd64; 8'd67: v = 8'd67;
      8'd68: v = 8'd71; 8'd69: v = 8'd74; 8'd70: v = 8'd78; 8'd71: v = 8'd82;
      8'd72: v = 8'd86; 8'd73: v = 8'd90; 8'd74: v = 8'd94; 8'd75: v = 8'd98;
      8'd76: v = 8'd103; 8'd77: v = 8'd107; 8'd78: v = 8'd112; 8'd79: v = 8'd117;
      8'd80: v = 8'd122; 8'd81: v = 8'd127; 8'd82: v = 8'd132; 8'd83: v = 8'd138;
      8'd84: v = 8'd143; 8'd85: v = 8'd149; 8'd86: v = 8'd155; 8'd87: v = 8'd161;
      8'd88: v = 8'd167; 8'd89: v = 8'd174; 8'd90: v = 8'd180; 8'd91: v = 8'd187;
      8'd92: v = 8'd194; 8'd93: v = 8'd201; 8'd94: v = 8'd208; 8'd95: v = 8'd215;
      8'd96: v = 8'd223; 8'd97: v = 8'd230; 8'd98: v = 8'd238; 8'd99: v = 8'd246;
      8'd100: v = 8'd254;
      default: begin
        // The table is symmetric: entry i equals entry 255 - i, with a flat top.
        j = 8'd255 - i;
        if (j <= 8'd100) v = breath_lut_half(j);
        else v = 8'd255;
      end
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/lsps_emitter.sv -----
module lsps_emitter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_ready,
  input  lsps_pkg::job_t  job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_frame_valid,
  output logic [3:0]      out_led_index,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [1:0]      out_timer_cmd,
  output logic [3:0]      out_timer_select,
  output logic            out_last
);

  lsps_pkg::job_t job_r;
  logic           busy_r;
  logic           second_r;
  logic [3:0]     led_r;
  logic           busy_nxt;
  logic           second_nxt;
  logic [3:0]     led_nxt;
  lsps_pkg::frame_t cur;
  logic           fin;
  logic           pixel_on;
  logic [3:0]     pos;

  // The emitter walks the held job one result per cycle while out_ready is high.
  assign job_ready = !busy_r || (out_ready && fin);
  assign cur = second_r ? job_r.f1 : job_r.f0;
  assign pos = lsps_pkg::ring_pos(led_r);

  always_comb begin
    unique case (cur.kind)
      lsps_pkg::FK_SOLID: pixel_on = 1'b1;
      lsps_pkg::FK_BAR:   pixel_on = pos < cur.count;
      default:            pixel_on = pos == cur.count;
    endcase
  end

  // Final result of a job: timer-only, or last LED of the last frame.
  assign fin = !(job_r.n_frames_1 || job_r.n_frames_2) ||
               (led_r == 4'(lsps_pkg::LedCount - 1) &&
                (second_r || !job_r.n_frames_2));

  assign out_valid        = busy_r;
  assign out_frame_valid  = job_r.n_frames_1 || job_r.n_frames_2;
  assign out_led_index    = out_frame_valid ? led_r : 4'd0;
  assign out_red          = (out_frame_valid && pixel_on) ? cur.red : 8'd0;
  assign out_green        = (out_frame_valid && pixel_on) ? cur.green : 8'd0;
  assign out_blue         = (out_frame_valid && pixel_on) ? cur.blue : 8'd0;
  assign out_last         = fin;
  assign out_timer_cmd    = fin ? job_r.tcmd : lsps_pkg::TC_LEAVE;
  assign out_timer_select = fin ? job_r.tsel : 4'd0;

  // Advance the position counters.
  always_comb begin
    busy_nxt   = busy_r;
    second_nxt = second_r;
    led_nxt    = led_r;
    if (busy_r && out_ready) begin
      if (fin) begin
        busy_nxt = 1'b0;
      end else if (led_r == 4'(lsps_pkg::LedCount - 1)) begin
        led_nxt    = 4'd0;
        second_nxt = 1'b1;
      end else begin
        led_nxt = led_r + 4'd1;
      end
    end
    if (job_valid && job_ready) begin
      busy_nxt   = 1'b1;
      second_nxt = 1'b0;
      led_nxt    = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      second_r <= 1'b0;
      led_r    <= 4'd0;
    end else begin
      busy_r   <= busy_nxt;
      second_r <= second_nxt;
      led_r    <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job;
    end
  end

endmodule

// ----- hdl/led_status_pattern_sequencer_top.sv -----
// LED status pattern sequencer for a 12-LED ring. Each accepted item (a mode
// command or a timer tick) is registered and decoded against the pattern state
// into up to two frames plus a timer command; the result channel then sends
// one result per cycle while out_ready is high: 12 per frame, 24 for a
// two-frame item, a single timer-only result, or none for an item with no work.
// The emitter sets the rate; the next item is decoded while the current one drains.
// Registers: 0x0 dialog_blinks (16 bits), 0x4 wake_blinks (7 bits).
`include "led_status_pattern_sequencer_top_defines.svh"
module led_status_pattern_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [3:0]  in_new_mode,
  input  logic [7:0]  in_level_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_valid,
  output logic [3:0]  out_led_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [1:0]  out_timer_cmd,
  output logic [3:0]  out_timer_select,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] ADDR_DIALOG = 3'd0;
  localparam logic [2:0] ADDR_WAKE   = 3'd4;

  logic [15:0] dialog_blinks_r;
  logic [6:0]  wake_blinks_r;

  // Input register.
  logic        iv_r;
  logic        req_r;
  logic [3:0]  nm_r;
  logic [7:0]  lvl_r;

  // Pattern state.
  logic [3:0]  mode_r, mode_nxt;
  logic [3:0]  pmode_r, pmode_nxt;
  logic [7:0]  plvl_r, plvl_nxt;
  logic        pflag_r, pflag_nxt;
  logic [7:0]  step_r, step_nxt;
  logic [15:0] flash_r, flash_nxt;
  logic        lit_r, lit_nxt;
  logic [3:0]  target_r, target_nxt;
  logic        hold_r, hold_nxt;

  lsps_pkg::job_t job;
  logic        job_ready;
  logic        job_valid;
  logic        emit_any;
  logic        do_apply;
  logic [3:0]  am;
  logic [7:0]  al;
  logic [3:0]  clamp;
  logic [15:0] flash_inc;
  logic        w_lit;

  assign cfg_pready = 1'b1;

  // Configuration writes and reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dialog_blinks_r <= 16'd3;
      wake_blinks_r   <= 7'd2;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr)
        ADDR_DIALOG: dialog_blinks_r <= cfg_pwdata[15:0];
        ADDR_WAKE:   wake_blinks_r   <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      ADDR_DIALOG: cfg_prdata = {16'd0, dialog_blinks_r};
      ADDR_WAKE:   cfg_prdata = {25'd0, wake_blinks_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // The input register empties or reloads whenever the emitter is ready for a job, also when the item makes no job.
  assign in_ready  = !iv_r || job_ready;
  assign job_valid = iv_r && emit_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_ready) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req_type;
      nm_r  <= in_new_mode;
      lvl_r <= in_level_value;
    end
  end

  function automatic lsps_pkg::frame_t solid(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    lsps_pkg::frame_t f;
    f.kind = lsps_pkg::FK_SOLID;
    f.red = r; f.green = g; f.blue = b; f.count = 4'd0;
    return f;
  endfunction

  function automatic lsps_pkg::frame_t bar(input logic [7:0] r, input logic [7:0] g,
                                           input logic [3:0] n);
    lsps_pkg::frame_t f;
    f.kind = lsps_pkg::FK_BAR;
    f.red = r; f.green = g; f.blue = 8'd0; f.count = n;
    return f;
  endfunction

  // Decode one item against the pattern state.
  always_comb begin
    mode_nxt = mode_r; pmode_nxt = pmode_r; plvl_nxt = plvl_r; pflag_nxt = pflag_r;
    step_nxt = step_r; flash_nxt = flash_r; lit_nxt = lit_r;
    target_nxt = target_r; hold_nxt = hold_r;
    job = '0;
    job.f0 = solid(8'd0, 8'd0, 8'd0);
    job.f1 = solid(8'd0, 8'd0, 8'd0);
    do_apply = 1'b0;
    am = nm_r;
    al = lvl_r;
    clamp = 4'd0;
    flash_inc = (flash_r != 16'hFFFF) ? flash_r + 16'd1 : flash_r;
    w_lit = 1'b0;

    if (req_r) begin
      if (nm_r <= lsps_pkg::M_STANDBY) begin
        if (mode_r == lsps_pkg::M_SELF && nm_r != lsps_pkg::M_SELF) begin
          pmode_nxt = nm_r; plvl_nxt = lvl_r; pflag_nxt = 1'b1;
        end else begin
          do_apply = 1'b1;
        end
      end
    end else begin
      case (mode_r)
        lsps_pkg::M_SELF: begin
          step_nxt = step_r + 8'd1;
          if (step_r == 8'd0) begin
            job.n_frames_1 = 1'b1; job.f0 = solid(8'd0, 8'd255, 8'd0);
            job.tcmd = lsps_pkg::TC_START; job.tsel = lsps_pkg::TS_SELF_G;
          end else if (step_r == 8'd1) begin
            job.n_frames_1 = 1'b1; job.f0 = solid(8'd0, 8'd0, 8'd255);
            job.tcmd = lsps_pkg::TC_START; job.tsel = lsps_pkg::TS_SELF_B;
          end else begin
            mode_nxt = lsps_pkg::M_IDLE;
            if (pflag_r) begin
              pflag_nxt = 1'b0; do_apply = 1'b1; am = pmode_r; al = plvl_r;
            end else begin
              job.n_frames_1 = 1'b1;
            end
          end
        end
        lsps_pkg::M_CFGOK: begin
          if (!hold_r) begin
            if (step_r < {4'd0, target_r}) begin
              step_nxt = step_r + 8'd1;
              job.n_frames_1 = 1'b1;
              job.f0 = bar(8'd0, 8'd255, step_nxt[3:0]);
              job.tcmd = lsps_pkg::TC_START;
              if (step_nxt >= {4'd0, target_r}) begin
                hold_nxt = 1'b1; job.tsel = lsps_pkg::TS_BAR_HOLD;
              end else begin
                job.tsel = lsps_pkg::TS_BAR_STEP;
              end
            end else begin
              hold_nxt = 1'b1;
              job.tcmd = lsps_pkg::TC_START; job.tsel = lsps_pkg::TS_BAR_HOLD;
            end
          end else begin
            mode_nxt = lsps_pkg::M_IDLE; job.n_frames_1 = 1'b1;
          end
        end
        lsps_pkg::M_VOLUME: begin
          mode_nxt = lsps_pkg::M_IDLE; job.n_frames_1 = 1'b1;
        end
        lsps_pkg::M_DIALOG: begin
          job.n_frames_1 = 1'b1;
          if (lit_r) begin
            lit_nxt = 1'b0;
            job.tcmd = lsps_pkg::TC_START; job.tsel = lsps_pkg::TS_DLG_OFF;
          end else begin
            job.f0 = solid(8'd0, 8'd0, 8'd255); lit_nxt = 1'b1;
            flash_nxt = flash_inc;
            if (flash_inc >= dialog_blinks_r) begin
              mode_nxt = lsps_pkg::M_IDLE; job.n_frames_2 = 1'b1;
            end else begin
              job.tcmd = lsps_pkg::TC_START; job.tsel = lsps_pkg::TS_DLG_ON;
            end
          end
        end
        lsps_pkg::M_CFGING: begin
          job.n_frames_1 = 1'b1; job.tcmd = lsps_pkg::TC_START;
          if (lit_r) begin
            lit_nxt = 1'b0; job.tsel = lsps_pkg::TS_CFG_OFF;
          end else begin
            lit_nxt = 1'b1; job.f0 = solid(8'd0, 8'd255, 8'd0);
            job.tsel = lsps_pkg::TS_CFG_ON;
          end
        end
        lsps_pkg::M_BREATHE: begin
          step_nxt = step_r + 8'd1;
          job.n_frames_1 = 1'b1;
          job.f0 = solid(8'd0, 8'd0, lsps_pkg::breath_lut(step_nxt));
          job.tcmd = lsps_pkg::TC_START; job.tsel = lsps_pkg::TS_BREATH;
        end
        lsps_pkg::M_WAKE: begin
          job.n_frames_1 = 1'b1;
          if (!hold_r) begin
            w_lit = !lit_r;
            lit_nxt = w_lit;
            job.f0 = solid(8'd0, 8'd0, w_lit ? 8'd255 : 8'd0);
            flash_nxt = flash_inc;
            job.tcmd = lsps_pkg::TC_START;
            if (flash_inc >= {8'd0, wake_blinks_r, 1'b0}) begin
              job.n_frames_2 = 1'b1; job.f1 = solid(8'd0, 8'd0, 8'd255);
              hold_nxt = 1'b1; job.tsel = lsps_pkg::TS_WAKE_HLD;
            end else begin
              job.tsel = lsps_pkg::TS_WAKE;
            end
          end else begin
            mode_nxt = lsps_pkg::M_IDLE;
          end
        end
        lsps_pkg::M_STANDBY: begin
          step_nxt = (step_r + 8'd1 >= 8'(lsps_pkg::LedCount)) ? 8'd0 : step_r + 8'd1;
          job.n_frames_1 = 1'b1;
          job.f0.kind = lsps_pkg::FK_CHASE; job.f0.green = 8'd255;
          job.f0.count = step_nxt[3:0];
          job.tcmd = lsps_pkg::TC_START; job.tsel = lsps_pkg::TS_CHASE;
        end
        default: ;
      endcase
    end

    // Start a new pattern; overrides any frame set above.
    if (do_apply) begin
      clamp = (al > 8'(lsps_pkg::LedCount)) ? 4'(lsps_pkg::LedCount) : al[3:0];
      step_nxt = 8'd0; flash_nxt = 16'd0; lit_nxt = 1'b0;
      target_nxt = 4'd0; hold_nxt = 1'b0;
      mode_nxt = am;
      job.n_frames_1 = 1'b1; job.n_frames_2 = 1'b0;
      job.f0 = solid(8'd0, 8'd0, 8'd0);
      job.tcmd = lsps_pkg::TC_START; job.tsel = 4'd0;
      unique case (am)
        lsps_pkg::M_IDLE: job.tcmd = lsps_pkg::TC_STOP;
        lsps_pkg::M_SELF: begin
          job.f0 = solid(8'd255, 8'd0, 8'd0); job.tsel = lsps_pkg::TS_SELF_R;
        end
        lsps_pkg::M_CFGING: begin
          job.f0 = solid(8'd0, 8'd255, 8'd0); lit_nxt = 1'b1;
          job.tsel = lsps_pkg::TS_CFG_ON;
        end
        lsps_pkg::M_CFGOK: begin
          target_nxt = clamp;
          if (clamp == 4'd0) begin
            hold_nxt = 1'b1; job.tsel = lsps_pkg::TS_BAR_HOLD;
          end else begin
            step_nxt = 8'd1; job.f0 = bar(8'd0, 8'd255, 4'd1);
            job.tsel = lsps_pkg::TS_BAR_STEP;
          end
        end
        lsps_pkg::M_NETERR: begin
          job.f0 = solid(8'd255, 8'd0, 8'd0); job.tcmd = lsps_pkg::TC_STOP;
        end
        lsps_pkg::M_DIALOG: begin
          job.f0 = solid(8'd0, 8'd0, 8'd255); lit_nxt = 1'b1;
          job.tsel = lsps_pkg::TS_DLG_ON;
        end
        lsps_pkg::M_VOLUME: begin
          job.f0 = bar(8'd255, 8'd255, clamp); job.tsel = lsps_pkg::TS_VOLUME;
        end
        lsps_pkg::M_BREATHE: begin
          job.n_frames_1 = 1'b0; job.tsel = lsps_pkg::TS_BREATH;
        end
        lsps_pkg::M_WAKE: begin
          job.f0 = solid(8'd0, 8'd0, 8'd255); lit_nxt = 1'b1;
          job.tsel = lsps_pkg::TS_WAKE;
        end
        default: begin
          job.f0.kind = lsps_pkg::FK_CHASE; job.f0.green = 8'd255;
          job.f0.count = 4'd0; job.tsel = lsps_pkg::TS_CHASE;
        end
      endcase
    end
    emit_any = job.n_frames_1 || job.n_frames_2 || (job.tcmd != lsps_pkg::TC_LEAVE);
  end

  // Two-frame jobs use f0 then f1; mark the first frame present too.
  lsps_pkg::job_t job_out;
  always_comb begin
    job_out = job;
    if (job.n_frames_2) job_out.n_frames_1 = 1'b1;
  end

  // Commit the state when the registered item is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lsps_pkg::M_IDLE; pmode_r <= 4'd0; plvl_r <= 8'd0; pflag_r <= 1'b0;
      step_r <= 8'd0; flash_r <= 16'd0; lit_r <= 1'b0; target_r <= 4'd0;
      hold_r <= 1'b0;
    end else if (iv_r && in_ready) begin
      mode_r <= mode_nxt; pmode_r <= pmode_nxt; plvl_r <= plvl_nxt;
      pflag_r <= pflag_nxt; step_r <= step_nxt; flash_r <= flash_nxt;
      lit_r <= lit_nxt; target_r <= target_nxt; hold_r <= hold_nxt;
    end
  end

  lsps_emitter u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (job_valid),
    .job_ready        (job_ready),
    .job              (job_out),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_valid  (out_frame_valid),
    .out_led_index    (out_led_index),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_timer_cmd    (out_timer_cmd),
    .out_timer_select (out_timer_select),
    .out_last         (out_last)
  );

  `LSPS_ASSERT_IMP(a_tcmd_only_last, clk, rst_n, out_valid && !out_last,
    out_timer_cmd == lsps_pkg::TC_LEAVE)
  `LSPS_ASSERT_IMP(a_led_range, clk, rst_n, out_valid, out_led_index < 4'd12)
  `LSPS_ASSERT_NXT(a_park_silent, clk, rst_n,
    iv_r && in_ready && req_r && mode_r == lsps_pkg::M_SELF && nm_r != lsps_pkg::M_SELF
    && nm_r <= lsps_pkg::M_STANDBY, pflag_r)

endmodule
